/* src/handheld_console_dma_controller_unit_assert.svh */
// Assertion macros shared by the DMA controller RTL.
// Each macro checks under clk with rst as the disable condition.
`ifndef HANDHELD_CONSOLE_DMA_CONTROLLER_UNIT_ASSERT_SVH
`define HANDHELD_CONSOLE_DMA_CONTROLLER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define HDC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dma controller assertion failed");
// Next-cycle implication.
`define HDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dma controller assertion failed");
`else
`define HDC_ASSERT_NOW(lbl, ante, cons)
`define HDC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* src/hdc_pkg.sv */
// Types and constants for the handheld DMA controller.
// No dependencies; used by hdc_core and the top level.
package hdc_pkg;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] write_value;
    logic       cpu_halted;
  } in_t;

  typedef struct packed {
    logic        xfer_valid;
    logic        xfer_to_oam;
    logic [15:0] xfer_source;
    logic [15:0] xfer_dest;
    logic [11:0] xfer_length;
    logic [15:0] source_now;
    logic [12:0] dest_now;
    logic [7:0]  control_readback;
    logic        hblank_mode_active;
    logic [7:0]  oam_page_readback;
  } out_t;

  localparam logic [2:0] OP_DMA    = 3'd0;
  localparam logic [2:0] OP_HDMA1  = 3'd1;
  localparam logic [2:0] OP_HDMA2  = 3'd2;
  localparam logic [2:0] OP_HDMA3  = 3'd3;
  localparam logic [2:0] OP_HDMA4  = 3'd4;
  localparam logic [2:0] OP_HDMA5  = 3'd5;
  localparam logic [2:0] OP_HBLANK = 3'd6;

  localparam logic [15:0] OAM_BASE   = 16'hFE00;
  localparam logic [11:0] OAM_LENGTH = 12'd160;
  localparam logic [11:0] BLOCK_LEN  = 12'd16;
  localparam logic [7:0]  COUNT_IDLE = 8'hFF;

endpackage

/* src/hdc_core.sv */
// Register file and descriptor logic of the DMA controller.
// Depends on hdc_pkg and the assertion macro header.
`include "handheld_console_dma_controller_unit_assert.svh"

module hdc_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  hdc_pkg::in_t  item,
  output hdc_pkg::out_t result
);
  import hdc_pkg::*;

  logic [15:0] source_address, source_address_next;
  logic [12:0] dest_address, dest_address_next;
  logic        hblank_running, hblank_running_next;
  logic [7:0]  block_count, block_count_next;
  logic [7:0]  oam_page, oam_page_next;

  logic [11:0] gen_length;
  logic [7:0]  count_dec;

  assign gen_length = ({5'd0, item.write_value[6:0]} + 12'd1) << 4;
  assign count_dec  = block_count - 8'd1;

  always_comb begin
    source_address_next = source_address;
    dest_address_next   = dest_address;
    hblank_running_next = hblank_running;
    block_count_next    = block_count;
    oam_page_next       = oam_page;
    result              = '0;
    unique case (item.op)
      OP_DMA: begin
        oam_page_next      = item.write_value;
        result.xfer_valid  = 1'b1;
        result.xfer_to_oam = 1'b1;
        result.xfer_source = {item.write_value, 8'd0};
        result.xfer_dest   = OAM_BASE;
        result.xfer_length = OAM_LENGTH;
      end
      OP_HDMA1: source_address_next = {item.write_value, source_address[7:4], 4'd0};
      OP_HDMA2: source_address_next = {source_address[15:8], item.write_value[7:4], 4'd0};
      OP_HDMA3: dest_address_next = {item.write_value[4:0], dest_address[7:4], 4'd0};
      OP_HDMA4: dest_address_next = {dest_address[12:8], item.write_value[7:4], 4'd0};
      OP_HDMA5: begin
        if (hblank_running) begin
          if (item.write_value[7]) begin
            block_count_next = {1'b0, item.write_value[6:0]};
          end else begin
            block_count_next    = COUNT_IDLE;
            hblank_running_next = 1'b0;
          end
        end else if (item.write_value[7]) begin
          hblank_running_next = 1'b1;
          block_count_next    = {1'b0, item.write_value[6:0]};
        end else begin
          result.xfer_valid   = 1'b1;
          result.xfer_source  = source_address;
          result.xfer_dest    = {3'd0, dest_address};
          result.xfer_length  = gen_length;
          source_address_next = source_address + {4'd0, gen_length};
          dest_address_next   = dest_address + {1'b0, gen_length};
          block_count_next    = COUNT_IDLE;
        end
      end
      OP_HBLANK: begin
        if (hblank_running && !item.cpu_halted) begin
          result.xfer_valid   = 1'b1;
          result.xfer_source  = source_address;
          result.xfer_dest    = {3'd0, dest_address};
          result.xfer_length  = BLOCK_LEN;
          source_address_next = source_address + {4'd0, BLOCK_LEN};
          dest_address_next   = dest_address + {1'b0, BLOCK_LEN};
          block_count_next    = count_dec;
          // end the run when the count wraps
          if (count_dec == COUNT_IDLE) begin
            hblank_running_next = 1'b0;
          end
        end
      end
      default: ;
    endcase
    result.source_now         = source_address_next;
    result.dest_now           = dest_address_next;
    result.control_readback   = block_count_next;
    result.hblank_mode_active = hblank_running_next;
    result.oam_page_readback  = oam_page_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_address <= '0;
      dest_address   <= '0;
      hblank_running <= 1'b0;
      block_count    <= COUNT_IDLE;
      oam_page       <= '0;
    end else if (fire) begin
      source_address <= source_address_next;
      dest_address   <= dest_address_next;
      hblank_running <= hblank_running_next;
      block_count    <= block_count_next;
      oam_page       <= oam_page_next;
    end
  end

  `HDC_ASSERT_NOW(a_idle_count, !hblank_running, block_count == COUNT_IDLE)
  `HDC_ASSERT_NOW(a_oam_has_copy, fire && result.xfer_to_oam, result.xfer_valid)
  `HDC_ASSERT_NEXT(a_no_fire_hold, !fire,
                   $stable(source_address) && $stable(dest_address) && $stable(block_count))

endmodule

/* src/handheld_console_dma_controller_unit.sv */
// Top level of the handheld DMA controller: input and result registers.
// Depends on hdc_pkg, hdc_core and the assertion macro header.
//
// Usage:
//   Input channel (in_valid, in_stall, in_word) carries one word per register
//   write (DMA, HDMA1..HDMA5) or horizontal-blank tick. Output channel
//   (out_valid, out_stall, out_word) returns exactly one word per input word:
//   a copy descriptor (valid, target, source, destination, length) plus the
//   register readbacks as they stand after that input word.
//   Path: a word accepted on the input channel is registered in the input
//   register, processed by the descriptor logic and loaded into the result
//   register when the output channel advances, which raises out_valid.
//   Throughput: one word per cycle while out_stall is low, as hdc_core updates
//   its registers at the same edge that loads the result register.
//   Stall: while the result register holds an untaken word and out_stall is
//   high, the input register holds too and in_stall rises once it is full.
//   Reset (rst, synchronous): both channel stages empty, addresses and OAM
//   page zero, hblank transfer idle, HDMA5 readback 0xFF.
`include "handheld_console_dma_controller_unit_assert.svh"

module handheld_console_dma_controller_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  hdc_pkg::in_t  in_word,
  output logic          out_valid,
  input  logic          out_stall,
  output hdc_pkg::out_t out_word
);
  import hdc_pkg::*;

  logic s1_valid;
  in_t  s1_word;
  logic advance;
  logic fire;
  out_t result;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign fire     = s1_valid && advance;

  hdc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (s1_word),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_word <= in_word;
    end
    if (fire) begin
      out_word <= result;
    end
  end

  `HDC_ASSERT_NOW(a_stall_only_full, in_stall, s1_valid && out_valid && out_stall)
  `HDC_ASSERT_NEXT(a_fire_fills_out, fire, out_valid)
  `HDC_ASSERT_NEXT(a_drain_empties, out_valid && !out_stall && !s1_valid, !out_valid)

endmodule

/* bench/dma_descriptor_checker.sv */
// Descriptor checker for the handheld DMA controller: watches both channels,
// predicts each result word from its own register state and compares fields.
// Depends on hdc_pkg for the word types and register codes.
module dma_descriptor_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_stall,
  input  hdc_pkg::in_t  in_word,
  input  logic          out_valid,
  input  logic          out_stall,
  input  hdc_pkg::out_t out_word,
  output int            fail_count,
  output int            pending
);
  import hdc_pkg::*;

  logic [15:0] src_addr;
  logic [12:0] vram_offset;
  logic        hblank_on;
  logic [7:0]  blocks_left;
  logic [7:0]  oam_page;
  out_t        descriptor_q[$];

  task automatic advance_addresses(input logic [11:0] len);
    src_addr = src_addr + {4'h0, len};
    vram_offset = vram_offset + {1'b0, len};
  endtask

  // Update the register state for one word and build the descriptor it gives.
  task automatic apply_word(input in_t w, output out_t r);
    logic [7:0]  v;
    logic [11:0] len;
    v = w.write_value;
    r = '0;
    case (w.op)
      OP_DMA: begin
        oam_page = v;
        r.xfer_valid = 1'b1;
        r.xfer_to_oam = 1'b1;
        r.xfer_source = {v, 8'h00};
        r.xfer_dest = OAM_BASE;
        r.xfer_length = OAM_LENGTH;
      end
      OP_HDMA1: src_addr = {v, src_addr[7:4], 4'h0};
      OP_HDMA2: src_addr = {src_addr[15:8], v[7:4], 4'h0};
      OP_HDMA3: vram_offset = {v[4:0], vram_offset[7:4], 4'h0};
      OP_HDMA4: vram_offset = {vram_offset[12:8], v[7:4], 4'h0};
      OP_HDMA5: begin
        if (hblank_on) begin
          if (v[7]) begin
            blocks_left = {1'b0, v[6:0]};
          end else begin
            // cancel a running hblank transfer
            blocks_left = COUNT_IDLE;
            hblank_on = 1'b0;
          end
        end else if (v[7]) begin
          hblank_on = 1'b1;
          blocks_left = {1'b0, v[6:0]};
        end else begin
          len = {1'b0, v[6:0], 4'h0} + BLOCK_LEN;
          r.xfer_valid = 1'b1;
          r.xfer_source = src_addr;
          r.xfer_dest = {3'b000, vram_offset};
          r.xfer_length = len;
          advance_addresses(len);
          blocks_left = COUNT_IDLE;
        end
      end
      OP_HBLANK: begin
        if (hblank_on && !w.cpu_halted) begin
          r.xfer_valid = 1'b1;
          r.xfer_source = src_addr;
          r.xfer_dest = {3'b000, vram_offset};
          r.xfer_length = BLOCK_LEN;
          advance_addresses(BLOCK_LEN);
          blocks_left = blocks_left - 8'd1;
          if (blocks_left == COUNT_IDLE) hblank_on = 1'b0;
        end
      end
      default: ;
    endcase
    r.source_now = src_addr;
    r.dest_now = vram_offset;
    r.control_readback = blocks_left;
    r.hblank_mode_active = hblank_on;
    r.oam_page_readback = oam_page;
  endtask

  task automatic check_field(input string field, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      if (fail_count < 10)
        $display("%0t: %s differs, expected %h, got %h", $realtime, field, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_t want;
    out_t next_r;
    if (rst) begin
      src_addr = '0;
      vram_offset = '0;
      hblank_on = 1'b0;
      blocks_left = COUNT_IDLE;
      oam_page = '0;
      fail_count = 0;
      descriptor_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (descriptor_q.size() == 0) begin
          if (fail_count < 10) $display("%0t: result word with none pending", $realtime);
          fail_count++;
        end else begin
          want = descriptor_q.pop_front();
          check_field("xfer_valid", 16'(want.xfer_valid), 16'(out_word.xfer_valid));
          check_field("xfer_to_oam", 16'(want.xfer_to_oam), 16'(out_word.xfer_to_oam));
          check_field("xfer_source", want.xfer_source, out_word.xfer_source);
          check_field("xfer_dest", want.xfer_dest, out_word.xfer_dest);
          check_field("xfer_length", 16'(want.xfer_length), 16'(out_word.xfer_length));
          check_field("source_now", want.source_now, out_word.source_now);
          check_field("dest_now", 16'(want.dest_now), 16'(out_word.dest_now));
          check_field("control_readback", 16'(want.control_readback),
                      16'(out_word.control_readback));
          check_field("hblank_mode_active", 16'(want.hblank_mode_active),
                      16'(out_word.hblank_mode_active));
          check_field("oam_page_readback", 16'(want.oam_page_readback),
                      16'(out_word.oam_page_readback));
        end
      end
      if (in_valid && !in_stall) begin
        apply_word(in_word, next_r);
        descriptor_q.push_back(next_r);
      end
    end
    pending = descriptor_q.size();
  end

endmodule

/* bench/tb.sv */
// Top of the DMA controller bench: clock, reset, word stimulus with random
// idling and stalls, and the verdict. Depends on hdc_pkg, the controller top
// level and dma_descriptor_checker.
module tb;
  import hdc_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_WORDS = 1000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_word;

  int   fail_count;
  int   pending;
  int   words_sent = 0;
  bit   jitter_on = 1'b1;
  bit   hold_req = 1'b0;

  handheld_console_dma_controller_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  dma_descriptor_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .fail_count(fail_count), .pending(pending)
  );

  always #6 clk = ~clk;

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stalls, or one long hold when asked.
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= jitter_on && ($urandom_range(99) < 29);
      end
    end
  end

  function automatic in_t mk(input logic [2:0] op, input logic [7:0] v,
                             input logic halted);
    in_t w;
    w.op = op;
    w.write_value = v;
    w.cpu_halted = halted;
    return w;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input in_t w);
    while (jitter_on && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic load_addresses();
    if ($urandom_range(4) != 0)
      send_word(mk(OP_HDMA1, 8'($urandom_range(255)), 1'($urandom_range(1))));
    if ($urandom_range(4) != 0)
      send_word(mk(OP_HDMA2, 8'($urandom_range(255)), 1'($urandom_range(1))));
    if ($urandom_range(4) != 0)
      send_word(mk(OP_HDMA3, 8'($urandom_range(255)), 1'($urandom_range(1))));
    if ($urandom_range(4) != 0)
      send_word(mk(OP_HDMA4, 8'($urandom_range(255)), 1'($urandom_range(1))));
  endtask

  task automatic hblank_run();
    logic [6:0] blocks;
    int ticks;
    int pick;
    blocks = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(6));
    send_word(mk(OP_HDMA5, {1'b1, blocks}, 1'($urandom_range(1))));
    ticks = int'(blocks) + 1 + int'($urandom_range(2));
    for (int i = 0; i < ticks; i++) begin
      pick = int'($urandom_range(99));
      if (pick < 4) begin
        send_word(mk(OP_HDMA5, {1'b1, 7'($urandom_range(5))}, 1'b0));
      end else if (pick < 8) begin
        send_word(mk(OP_HDMA5, {1'b0, 7'($urandom_range(127))}, 1'b0));
      end else if (pick < 13) begin
        send_word(mk(3'($urandom_range(4)), 8'($urandom_range(255)), 1'b0));
      end else begin
        send_word(mk(OP_HBLANK, 8'($urandom_range(255)), $urandom_range(99) < 20));
      end
    end
  endtask

  initial begin : stimulus
    int pick;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset readback, extremes, each HDMA5 path
    send_word(mk(OP_UNUSED, 8'hFF, 1'b1));
    send_word(mk(OP_DMA, 8'h00, 1'b0));
    send_word(mk(OP_DMA, 8'hFF, 1'b1));
    send_word(mk(OP_HDMA1, 8'hFF, 1'b0));
    send_word(mk(OP_HDMA2, 8'hFF, 1'b0));
    send_word(mk(OP_HDMA3, 8'hFF, 1'b0));
    send_word(mk(OP_HDMA4, 8'hFF, 1'b0));
    send_word(mk(OP_HDMA5, 8'h7F, 1'b0));
    send_word(mk(OP_HDMA5, 8'h00, 1'b1));
    send_word(mk(OP_HBLANK, 8'h00, 1'b0));
    send_word(mk(OP_HDMA1, 8'h00, 1'b0));
    send_word(mk(OP_HDMA3, 8'h00, 1'b0));
    send_word(mk(OP_HDMA5, 8'h81, 1'b0));
    send_word(mk(OP_HBLANK, 8'h00, 1'b1));
    send_word(mk(OP_HBLANK, 8'h00, 1'b0));
    send_word(mk(OP_HBLANK, 8'h00, 1'b0));
    send_word(mk(OP_HBLANK, 8'h00, 1'b0));
    send_word(mk(OP_HDMA5, 8'h85, 1'b0));
    send_word(mk(OP_HDMA5, 8'h83, 1'b0));
    send_word(mk(OP_HDMA5, 8'h00, 1'b0));
    send_word(mk(OP_HDMA5, 8'h80, 1'b0));
    send_word(mk(OP_HBLANK, 8'hFF, 1'b0));
    send_word(mk(OP_UNUSED, 8'h00, 1'b0));
    drain();

    // long receiver hold with back-to-back words to fill the pipeline
    jitter_on = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++)
      send_word(mk(3'($urandom_range(6)), 8'($urandom_range(255)),
                   1'($urandom_range(1))));
    drain();
    jitter_on = 1'b1;

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      jitter_on = (words_sent < 300 || words_sent >= 500);
      pick = int'($urandom_range(99));
      if (pick < 10) begin
        send_word(mk(3'($urandom_range(7)), 8'($urandom_range(255)),
                     1'($urandom_range(1))));
      end else if (pick < 20) begin
        send_word(mk(OP_DMA, 8'($urandom_range(255)), 1'($urandom_range(1))));
      end else begin
        load_addresses();
        if ($urandom_range(2) == 0)
          send_word(mk(OP_HDMA5, {1'b0, ($urandom_range(7) == 0) ?
                                 7'($urandom_range(127)) : 7'($urandom_range(7))},
                       1'($urandom_range(1))));
        else
          hblank_run();
      end
    end
    drain();
    repeat (8) @(negedge clk);

    if (fail_count == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
